// File: sv/chbs_pkg.sv
package chbs_pkg;

	localparam int HASH_W    = 32;
	localparam int INDEX_W   = 10;
	localparam int CFG_W     = 11;
	// one restoring quotient bit per cell
	localparam int DIV_STEPS = 32;

	localparam logic [HASH_W-1:0] FULL_RANGE = 32'hFFFF_FFFF;
	localparam logic [HASH_W-1:0] HALF_RANGE = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [HASH_W-1:0] rem;
		logic [HASH_W-1:0] quo;
		logic [HASH_W-1:0] dvsr;
	} lane_t;

	// lane a: part or slice, lane b: full range over candidate
	typedef struct packed {
		logic  vld;
		logic  first;
		lane_t a;
		lane_t b;
	} beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

endpackage

// File: sv/chbs_cell.sv
module chbs_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            flush,
	input  chbs_pkg::beat_t beat_in,
	output chbs_pkg::beat_t beat_out
);

	logic            vld_q;
	logic            first_q;
	chbs_pkg::lane_t a_q;
	chbs_pkg::lane_t b_q;

	// dividend is all ones, so every shifted-in bit is one
	function automatic chbs_pkg::lane_t div_step(input chbs_pkg::lane_t l);
		logic [chbs_pkg::HASH_W:0] t;
		logic [chbs_pkg::HASH_W:0] diff;
		chbs_pkg::lane_t           o;
		t    = {l.rem, 1'b1};
		diff = t - {1'b0, l.dvsr};
		o    = l;
		if (t >= {1'b0, l.dvsr}) begin
			o.rem = diff[chbs_pkg::HASH_W-1:0];
			o.quo = {l.quo[chbs_pkg::HASH_W-2:0], 1'b1};
		end else begin
			o.rem = t[chbs_pkg::HASH_W-1:0];
			o.quo = {l.quo[chbs_pkg::HASH_W-2:0], 1'b0};
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (flush) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= beat_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		first_q <= beat_in.first;
		a_q     <= div_step(beat_in.a);
		b_q     <= div_step(beat_in.b);
	end

	always_comb begin
		beat_out.vld   = vld_q;
		beat_out.first = first_q;
		beat_out.a     = a_q;
		beat_out.b     = b_q;
	end

endmodule

// File: sv/chbs_chain.sv
module chbs_chain (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        flush,
	input  logic                        start_vld,
	input  logic                        start_first,
	input  logic [chbs_pkg::HASH_W-1:0] dvsr_a,
	input  logic [chbs_pkg::HASH_W-1:0] dvsr_b,
	output chbs_pkg::beat_t             beat_out
);

	chbs_pkg::beat_t link [chbs_pkg::DIV_STEPS+1];

	// field order: vld, first, a (rem, quo, dvsr), b (rem, quo, dvsr)
	assign link[0] = {start_vld, start_first,
		{(2*chbs_pkg::HASH_W){1'b0}}, dvsr_a,
		{(2*chbs_pkg::HASH_W){1'b0}}, dvsr_b};

	for (genvar k = 0; k < chbs_pkg::DIV_STEPS; k++) begin : g_cell
		chbs_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.flush   (flush),
			.beat_in (link[k]),
			.beat_out(link[k+1])
		);
	end

	assign beat_out = link[chbs_pkg::DIV_STEPS];

endmodule

// File: sv/consistent_hash_bucket_select_core.sv
// Maps a 32-bit key hash to a bucket in 0..bucket_count-1 by the consistent-hashing walk over
// candidate buckets 3..bucket_count (bucket_count is clamped to MAX_BUCKETS, and 0 acts as 1).
// One item is worked at a time. A sequencer issues one candidate per cycle into a row of 32
// divider cells that produce the slice and range quotients; the walker behind them consumes
// one candidate per cycle, and the walk may stop early; when bucket_count is 0 or 1 no walk
// is run. The result sits in an output register, so the next item is taken while it waits.
// The user must write bucket_count only while idle; the block itself does not enforce it.
module consistent_hash_bucket_select_core #(
	parameter int MAX_BUCKETS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [chbs_pkg::HASH_W-1:0]  hash_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [chbs_pkg::INDEX_W-1:0] bucket_index,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [chbs_pkg::CFG_W-1:0]   bucket_count
);

	localparam int IW = $clog2(MAX_BUCKETS + 1);
	localparam int CW = (IW > chbs_pkg::CFG_W) ? IW : chbs_pkg::CFG_W;
	localparam int RW = (IW > chbs_pkg::INDEX_W) ? IW : chbs_pkg::INDEX_W;
	localparam int FW = 2 * IW;
	localparam int PW = chbs_pkg::HASH_W + IW;

	chbs_pkg::state_t state_q, state_nxt;

	logic [chbs_pkg::CFG_W-1:0]   cfg_q;
	logic [IW-1:0]                capa_eff;
	logic                         accept;
	logic                         walk_en;
	logic                         out_free;
	logic                         out_load;

	logic [chbs_pkg::HASH_W-1:0]  h_q;
	logic [IW-1:0]                n_q;
	logic [IW-1:0]                capa_q;
	logic [chbs_pkg::HASH_W-1:0]  part_q;
	logic [RW-1:0]                res_q;
	logic                         chg_q;

	logic                         out_vld_q;
	logic [chbs_pkg::INDEX_W-1:0] bucket_q;

	// feed sequencer
	logic                         fd_on_q;
	logic                         fd_first_q;
	logic [IW-1:0]                fi_q;
	logic [FW-1:0]                fprod;
	logic                         s1_vld_q;
	logic                         s1_first_s1;
	logic [chbs_pkg::HASH_W-1:0]  s1_da_s1;
	logic [chbs_pkg::HASH_W-1:0]  s1_db_s1;

	chbs_pkg::beat_t              chain_out;

	// walker input stage
	logic [IW-1:0]                factor;
	logic [PW-1:0]                wprod;
	logic                         w1_vld_q;
	logic                         w1_first_s2;
	logic [chbs_pkg::HASH_W-1:0]  w1_slice_s2;
	logic [chbs_pkg::HASH_W-1:0]  w1_li_s2;
	logic [IW-1:0]                w1_i_s2;
	logic [chbs_pkg::HASH_W-1:0]  w1_prod_s2;

	// walker step
	logic                         done_w;
	logic [RW-1:0]                res_w;
	logic [chbs_pkg::HASH_W-1:0]  h_nxt;
	logic [chbs_pkg::HASH_W-1:0]  h_add;
	logic [IW-1:0]                n_nxt;
	logic [chbs_pkg::HASH_W-1:0]  part_nxt;
	logic                         chg_nxt;

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_vld_q;
	assign bucket_index = bucket_q;
	assign out_free     = !out_vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= chbs_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= bucket_count;
		end
	end

	always_comb begin
		if (CW'(cfg_q) > CW'(MAX_BUCKETS)) begin
			capa_eff = IW'(MAX_BUCKETS);
		end else begin
			capa_eff = IW'(cfg_q);
		end
	end

	// fsm: next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			chbs_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = (capa_eff <= IW'(1)) ? chbs_pkg::ST_HOLD : chbs_pkg::ST_RUN;
				end
			end
			chbs_pkg::ST_RUN: begin
				if (done_w) begin
					state_nxt = chbs_pkg::ST_HOLD;
				end
			end
			chbs_pkg::ST_HOLD: begin
				if (out_free) begin
					state_nxt = chbs_pkg::ST_IDLE;
				end
			end
			default: state_nxt = chbs_pkg::ST_IDLE;
		endcase
	end

	// fsm: outputs
	always_comb begin
		in_stall = (state_q != chbs_pkg::ST_IDLE);
		walk_en  = (state_q == chbs_pkg::ST_RUN);
		out_load = (state_q == chbs_pkg::ST_HOLD) && out_free;
	end

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// feed: first slot carries the part divisor, then one gap, then candidates 3..capa
	assign fprod = FW'(fi_q) * FW'(fi_q - IW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fd_on_q    <= 1'b0;
			fd_first_q <= 1'b0;
			s1_vld_q   <= 1'b0;
		end else if (done_w) begin
			fd_on_q  <= 1'b0;
			s1_vld_q <= 1'b0;
		end else if (accept && (capa_eff > IW'(1))) begin
			fd_on_q    <= 1'b1;
			fd_first_q <= 1'b1;
			s1_vld_q   <= 1'b0;
		end else if (fd_on_q) begin
			if (fd_first_q) begin
				fd_first_q <= 1'b0;
				s1_vld_q   <= 1'b1;
			end else if (fi_q == IW'(2)) begin
				s1_vld_q <= 1'b0;
				if (capa_q == IW'(2)) begin
					fd_on_q <= 1'b0;
				end
			end else begin
				s1_vld_q <= 1'b1;
				if (fi_q == capa_q) begin
					fd_on_q <= 1'b0;
				end
			end
		end else begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fi_q <= IW'(2);
		end else if (fd_on_q && !fd_first_q) begin
			fi_q <= fi_q + IW'(1);
		end
		s1_first_s1 <= fd_first_q;
		if (fd_first_q) begin
			s1_da_s1 <= 32'(capa_q);
			s1_db_s1 <= 32'(capa_q);
		end else begin
			s1_da_s1 <= 32'(fprod);
			s1_db_s1 <= 32'(fi_q);
		end
	end

	chbs_chain u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.flush      (done_w),
		.start_vld  (s1_vld_q),
		.start_first(s1_first_s1),
		.dvsr_a     (s1_da_s1),
		.dvsr_b     (s1_db_s1),
		.beat_out   (chain_out)
	);

	// product for the add branch with n as it stands now; the walker zeroes it
	// when the candidate just before moved n
	assign factor = chain_out.b.dvsr[IW-1:0] - n_q - IW'(1);
	assign wprod  = PW'(chain_out.a.quo) * PW'(factor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_vld_q <= 1'b0;
		end else if (done_w) begin
			w1_vld_q <= 1'b0;
		end else begin
			w1_vld_q <= chain_out.vld;
		end
	end

	always_ff @(posedge clk) begin
		w1_first_s2 <= chain_out.first;
		w1_slice_s2 <= chain_out.a.quo;
		w1_li_s2    <= chain_out.b.quo;
		w1_i_s2     <= chain_out.b.dvsr[IW-1:0];
		w1_prod_s2  <= wprod[chbs_pkg::HASH_W-1:0];
	end

	always_comb begin
		done_w   = 1'b0;
		res_w    = '0;
		h_nxt    = h_q;
		n_nxt    = n_q;
		part_nxt = part_q;
		chg_nxt  = 1'b0;
		h_add    = h_q + (chg_q ? '0 : w1_prod_s2);
		if (walk_en && w1_vld_q) begin
			if (w1_first_s2) begin
				part_nxt = w1_slice_s2;
				if ((chbs_pkg::FULL_RANGE - h_q) < w1_slice_s2) begin
					done_w = 1'b1;
					res_w  = '0;
				end else if (h_q >= chbs_pkg::HALF_RANGE) begin
					h_nxt = h_q - chbs_pkg::HALF_RANGE;
					n_nxt = IW'(1);
					if (capa_q == IW'(2)) begin
						done_w = 1'b1;
						res_w  = RW'(1);
					end
				end else begin
					n_nxt = IW'(2);
					if (((chbs_pkg::HALF_RANGE - h_q) < w1_slice_s2) ||
					    (capa_q == IW'(2))) begin
						done_w = 1'b1;
						res_w  = RW'(1);
					end
				end
			end else if (w1_slice_s2 <= h_q) begin
				h_nxt = h_q - w1_slice_s2;
				if (w1_i_s2 == capa_q) begin
					done_w = 1'b1;
					res_w  = RW'(n_q) - RW'(1);
				end
			end else begin
				h_nxt   = h_add;
				n_nxt   = w1_i_s2;
				chg_nxt = 1'b1;
				if (((w1_li_s2 - h_add) < part_q) || (w1_i_s2 == capa_q)) begin
					done_w = 1'b1;
					res_w  = RW'(w1_i_s2) - RW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chg_q <= 1'b0;
		end else begin
			chg_q <= chg_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h_q    <= hash_value;
			capa_q <= capa_eff;
			res_q  <= '0;
		end else if (walk_en) begin
			h_q    <= h_nxt;
			n_q    <= n_nxt;
			part_q <= part_nxt;
			if (done_w) begin
				res_q <= res_w;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_vld_q && !out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			bucket_q <= res_q[chbs_pkg::INDEX_W-1:0];
		end
	end

	a_hold_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == chbs_pkg::ST_HOLD |-> !fd_on_q && !s1_vld_q && !w1_vld_q)
		else $error("pipeline not flushed while result is held");

	a_cand_range: assert property (@(posedge clk) disable iff (!arst_n)
		walk_en && w1_vld_q && !w1_first_s2 |-> (w1_i_s2 >= IW'(3)) && (w1_i_s2 <= capa_q))
		else $error("candidate bucket out of walk range");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		done_w |=> state_q == chbs_pkg::ST_HOLD)
		else $error("finished walk did not move to hold");

	a_single_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (capa_eff <= IW'(1)) |=> state_q == chbs_pkg::ST_HOLD && res_q == '0)
		else $error("single bucket did not yield bucket zero");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == chbs_pkg::ST_HOLD && capa_q > IW'(1) |-> res_q < RW'(capa_q))
		else $error("selected bucket not below bucket count");

endmodule

// File: tb/bucket_select_checker.sv
module bucket_select_checker #(
	parameter int MAX_BUCKETS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [chbs_pkg::HASH_W-1:0]  hash_value,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [chbs_pkg::INDEX_W-1:0] bucket_index,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [chbs_pkg::CFG_W-1:0]   bucket_count,
	output int                           fail_count,
	output int                           pending,
	output int                           results_checked
);

	typedef struct {
		logic [chbs_pkg::HASH_W-1:0]  key;
		logic [chbs_pkg::CFG_W-1:0]   count;
		logic [chbs_pkg::INDEX_W-1:0] bucket;
	} placement_t;

	placement_t                 expected_buckets[$];
	logic [chbs_pkg::CFG_W-1:0] count_shadow;

	function automatic logic [chbs_pkg::INDEX_W-1:0] pick_bucket(
		input logic [chbs_pkg::HASH_W-1:0] key,
		input logic [chbs_pkg::CFG_W-1:0] count);
		logic [31:0] h;
		logic [31:0] capa;
		logic [31:0] part;
		logic [31:0] slice;
		logic [31:0] n;
		logic [31:0] cand;
		logic [63:0] prod;
		h = key;
		capa = 32'(count);
		if (capa <= 32'd1)
			return '0;
		if (capa > 32'(MAX_BUCKETS))
			capa = 32'(MAX_BUCKETS);
		part = chbs_pkg::FULL_RANGE / capa;
		// top slice of the range belongs to bucket 0
		if (chbs_pkg::FULL_RANGE - h < part)
			return '0;
		n = 32'd1;
		if (h >= chbs_pkg::HALF_RANGE) begin
			h = h - chbs_pkg::HALF_RANGE;
		end else begin
			n = 32'd2;
			if (chbs_pkg::HALF_RANGE - h < part)
				return chbs_pkg::INDEX_W'(1);
		end
		if (capa == 32'd2)
			return chbs_pkg::INDEX_W'(1);
		for (cand = 32'd3; cand <= capa; cand++) begin
			prod = {32'd0, cand} * {32'd0, cand - 32'd1};
			slice = 32'({32'd0, chbs_pkg::FULL_RANGE} / prod);
			if (slice <= h) begin
				h = h - slice;
			end else begin
				// wraps mod 2^32 on purpose
				h = h + slice * (cand - n - 32'd1);
				n = cand;
				if (chbs_pkg::FULL_RANGE / cand - h < part)
					return chbs_pkg::INDEX_W'(n - 32'd1);
			end
		end
		return chbs_pkg::INDEX_W'(n - 32'd1);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		placement_t p;
		if (!arst_n) begin
			expected_buckets.delete();
			count_shadow <= chbs_pkg::CFG_W'(1);
			fail_count <= 0;
			pending <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				count_shadow <= bucket_count;
			if (in_valid && !in_stall) begin
				p.key = hash_value;
				p.count = count_shadow;
				p.bucket = pick_bucket(hash_value, count_shadow);
				expected_buckets.push_back(p);
			end
			if (out_valid && !out_stall) begin
				if (expected_buckets.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual bucket_index %0d",
						$time, bucket_index);
					fail_count <= fail_count + 1;
				end else begin
					p = expected_buckets.pop_front();
					results_checked <= results_checked + 1;
					if (bucket_index !== p.bucket) begin
						$display("%0t: key %h count %0d: bucket_index expected %0d actual %0d",
							$time, p.key, p.count, p.bucket, bucket_index);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_buckets.size();
		end
	end

endmodule

// File: tb/tb_top.sv
module tb_top;

	localparam int KEY_TARGET  = 580;
	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_WAIT  = 1100;

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [chbs_pkg::HASH_W-1:0]  hash_value = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [chbs_pkg::INDEX_W-1:0] bucket_index;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [chbs_pkg::CFG_W-1:0]   bucket_count = chbs_pkg::CFG_W'(1);

	int fail_count;
	int pending;
	int results_checked;
	int keys_sent = 0;
	int count_writes = 0;
	int send_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	consistent_hash_bucket_select_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.hash_value(hash_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bucket_index(bucket_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.bucket_count(bucket_count)
	);

	bucket_select_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.hash_value(hash_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bucket_index(bucket_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.bucket_count(bucket_count),
		.fail_count(fail_count),
		.pending(pending),
		.results_checked(results_checked)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				quiet_cycles, pending);
			$display("consistent_hash_bucket_select_core: mismatch");
			$finish;
		end
	end

	function automatic logic [chbs_pkg::HASH_W-1:0] range_part(
		input logic [chbs_pkg::CFG_W-1:0] count);
		int capa;
		capa = (count < 1) ? 1 : ((count > 1024) ? 1024 : int'(count));
		return chbs_pkg::FULL_RANGE / capa;
	endfunction

	// keys on and around the bucket 0 and halving boundaries
	function automatic logic [chbs_pkg::HASH_W-1:0] edge_key(
		input logic [chbs_pkg::CFG_W-1:0] count, input int sel);
		logic [chbs_pkg::HASH_W-1:0] part;
		part = range_part(count);
		case (sel)
			0: return '0;
			1: return chbs_pkg::FULL_RANGE;
			2: return chbs_pkg::HALF_RANGE;
			3: return chbs_pkg::HALF_RANGE + 32'd1;
			4: return chbs_pkg::FULL_RANGE - part;
			5: return chbs_pkg::FULL_RANGE - part + 32'd1;
			6: return chbs_pkg::HALF_RANGE - part;
			default: return chbs_pkg::HALF_RANGE - part + 32'd1;
		endcase
	endfunction

	function automatic logic [chbs_pkg::HASH_W-1:0] random_key(
		input logic [chbs_pkg::CFG_W-1:0] count);
		logic [chbs_pkg::HASH_W-1:0] part;
		part = range_part(count);
		case ($urandom_range(0, 7))
			0: return chbs_pkg::FULL_RANGE - part + $urandom_range(0, 4) - 32'd2;
			1: return chbs_pkg::HALF_RANGE - part + $urandom_range(0, 4) - 32'd2;
			2: return chbs_pkg::HALF_RANGE + $urandom_range(0, 4) - 32'd2;
			3: return ($urandom_range(0, 1) != 0) ? chbs_pkg::FULL_RANGE : '0;
			default: return $urandom();
		endcase
	endfunction

	task automatic push_key(input logic [chbs_pkg::HASH_W-1:0] key);
		int gap;
		case ((keys_sent / 29) % 4)
			0: begin send_pct = 0;  stall_pct = 0;  end
			1: begin send_pct = 63; stall_pct = 0;  end
			2: begin send_pct = 0;  stall_pct = 63; end
			default: begin send_pct = 24; stall_pct = 24; end
		endcase
		gap = 0;
		while ($urandom_range(0, 99) < send_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		hash_value <= key;
		do
			@(posedge clk);
		while (in_stall);
		keys_sent++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// only while idle: every placed key has come back
	task automatic write_count(input logic [chbs_pkg::CFG_W-1:0] count);
		drain();
		cfg_valid <= 1'b1;
		bucket_count <= count;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_writes++;
	endtask

	initial begin
		logic [chbs_pkg::CFG_W-1:0] count;
		int setting_no;
		int burst;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single bucket from reset, including key 0
		push_key('0);
		push_key(chbs_pkg::FULL_RANGE);
		// zero capacity acts as one
		write_count('0);
		push_key('0);
		push_key($urandom());
		// two buckets, then three: boundary keys
		write_count(chbs_pkg::CFG_W'(2));
		for (int s = 0; s < 8; s++)
			push_key(edge_key(chbs_pkg::CFG_W'(2), s));
		write_count(chbs_pkg::CFG_W'(3));
		for (int s = 0; s < 8; s++)
			push_key(edge_key(chbs_pkg::CFG_W'(3), s));

		setting_no = 0;
		while (keys_sent < KEY_TARGET) begin
			case (setting_no)
				2: count = chbs_pkg::CFG_W'(1024);
				5: count = chbs_pkg::CFG_W'(2047);
				8: count = chbs_pkg::CFG_W'(1025);
				default: begin
					case ($urandom_range(0, 9))
						0: count = chbs_pkg::CFG_W'($urandom_range(0, 2));
						7, 8: count = chbs_pkg::CFG_W'($urandom_range(65, 300));
						9: count = chbs_pkg::CFG_W'($urandom_range(301, 2047));
						default: count = chbs_pkg::CFG_W'($urandom_range(3, 64));
					endcase
				end
			endcase
			// long walks get only a handful of keys
			burst = (count > 300) ? 5 : $urandom_range(15, 35);
			write_count(count);
			repeat (burst)
				push_key(random_key(count));
			setting_no++;
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("placed %0d keys over %0d bucket_count writes, counts 0 to 2047",
			keys_sent, count_writes);
		$display("compared %0d bucket indexes with and without handshake idling",
			results_checked);
		if (fail_count == 0 && pending == 0)
			$display("consistent_hash_bucket_select_core: match");
		else
			$display("consistent_hash_bucket_select_core: mismatch");
		$finish;
	end

endmodule
